FILE: rtl/u8u16_pkg.sv
// Package with shared types and constants of the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

    // Field widths of the channels and the configuration register.
    localparam int BYTE_W   = 8;
    localparam int UNIT_W   = 16;
    localparam int COUNT_W  = 13;
    localparam int ACC_W    = 21;

    // Hard capacity of a destination buffer and the reset value of the limit.
    localparam logic [COUNT_W-1:0] MAX_UNITS   = COUNT_W'(4096);
    localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(256);

    // Result queue depth; one byte can push up to three items.
    localparam int MAX_PUSH = 3;
    localparam int Q_DEPTH  = 4;
    localparam int PTR_W    = $clog2(Q_DEPTH);
    localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

    // Surrogate encoding constants.
    localparam logic [ACC_W-1:0]  SUPP_BASE = ACC_W'(20'h10000);
    localparam logic [UNIT_W-1:0] HI_SURR   = 16'hD800;
    localparam logic [UNIT_W-1:0] LO_SURR   = 16'hDC00;

    // Closing status codes.
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_LEAD = 3'd1,
        ST_BAD_CONT = 3'd2,
        ST_TRUNC    = 3'd3,
        ST_NO_ROOM  = 3'd4
    } t_status;

    // One result item.
    typedef struct packed {
        logic [UNIT_W-1:0]  code_unit;
        logic               is_unit;
        t_status            status;
        logic [COUNT_W-1:0] unit_count;
        logic               end_of_run;
    } t_item;

    // Items produced by one byte, in order, and how many of them there are.
    typedef struct packed {
        logic [1:0]              num;
        t_item [MAX_PUSH-1:0]    item;
    } t_push;

endpackage

FILE: rtl/u8u16_decode.sv
// Per-byte UTF-8 decoder with string state and UTF-16 unit generation.
module u8u16_decode
    import u8u16_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic [BYTE_W-1:0]  i_byte,
    input  logic               i_last,
    input  logic [COUNT_W-1:0] i_limit,
    output t_push              o_push
);

    logic [ACC_W-1:0]   r_acc,   n_acc;
    logic [1:0]         r_pend,  n_pend;
    logic [COUNT_W-1:0] r_units, n_units;
    t_status            r_err,   n_err;
    logic               r_full,  n_full;

    // String state advances only when a byte is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_pend  <= '0;
            r_units <= '0;
            r_err   <= ST_OK;
            r_full  <= 1'b0;
        end else if (i_take) begin
            r_acc   <= n_acc;
            r_pend  <= n_pend;
            r_units <= n_units;
            r_err   <= n_err;
            r_full  <= n_full;
        end
    end

    logic [COUNT_W-1:0] limit;
    logic               done;
    logic [ACC_W-1:0]   cp;
    logic [ACC_W-1:0]   supp;
    logic [1:0]         slot;
    t_item              unit_item;

    // Decode the byte, emit the finished code point and close the string.
    always_comb begin
        limit   = (i_limit > MAX_UNITS) ? MAX_UNITS : i_limit;
        n_acc   = r_acc;
        n_pend  = r_pend;
        n_units = r_units;
        n_err   = r_err;
        n_full  = r_full;
        done    = 1'b0;
        slot    = 2'd0;
        o_push  = '0;
        supp    = '0;

        unit_item            = '0;
        unit_item.is_unit    = 1'b1;
        unit_item.status     = ST_OK;

        if (r_err == ST_OK && !r_full) begin
            if (r_pend == 2'd0) begin
                priority if (r_units >= limit) begin
                    n_full = 1'b1;
                end else if (i_byte[7] == 1'b0) begin
                    n_acc = ACC_W'(i_byte);
                    done  = 1'b1;
                end else if (i_byte[7:5] == 3'b110) begin
                    n_acc  = ACC_W'(i_byte[4:0]);
                    n_pend = 2'd1;
                end else if (i_byte[7:4] == 4'b1110) begin
                    n_acc  = ACC_W'(i_byte[3:0]);
                    n_pend = 2'd2;
                end else if (i_byte[7:3] == 5'b11110) begin
                    n_acc  = ACC_W'(i_byte[2:0]);
                    n_pend = 2'd3;
                end else begin
                    n_err = ST_BAD_LEAD;
                end
            end else if (i_byte[7:6] != 2'b10) begin
                n_err = ST_BAD_CONT;
            end else begin
                n_acc  = {r_acc[ACC_W-7:0], i_byte[5:0]};
                n_pend = r_pend - 2'd1;
                done   = (r_pend == 2'd1);
            end
        end

        cp = n_acc;

        // A finished code point gives one unit or a surrogate pair.
        if (done) begin
            if (cp[ACC_W-1:UNIT_W] == '0) begin
                if (r_units < limit) begin
                    n_units              = r_units + COUNT_W'(1);
                    unit_item.code_unit  = cp[UNIT_W-1:0];
                    unit_item.unit_count = n_units;
                    o_push.item[0]       = unit_item;
                    slot                 = 2'd1;
                end
            end else begin
                supp = cp - SUPP_BASE;
                if ({1'b0, r_units} + (COUNT_W+1)'(1) < {1'b0, limit}) begin
                    unit_item.code_unit  = HI_SURR | UNIT_W'(supp[19:10]);
                    unit_item.unit_count = r_units + COUNT_W'(1);
                    o_push.item[0]       = unit_item;
                    unit_item.code_unit  = LO_SURR | UNIT_W'(supp[9:0]);
                    unit_item.unit_count = r_units + COUNT_W'(2);
                    o_push.item[1]       = unit_item;
                    n_units              = r_units + COUNT_W'(2);
                    slot                 = 2'd2;
                end else begin
                    n_err = ST_NO_ROOM;
                end
            end
            n_acc = '0;
        end

        // The flagged byte adds the closing item and clears the string state.
        if (i_last) begin
            if (n_err == ST_OK && !n_full && n_pend != 2'd0) begin
                n_err = ST_TRUNC;
            end
            o_push.item[slot].code_unit  = '0;
            o_push.item[slot].is_unit    = 1'b0;
            o_push.item[slot].status     = n_err;
            o_push.item[slot].unit_count = n_units;
            o_push.item[slot].end_of_run = 1'b1;
            slot    = slot + 2'd1;
            n_acc   = '0;
            n_pend  = '0;
            n_units = '0;
            n_err   = ST_OK;
            n_full  = 1'b0;
        end

        o_push.num = i_take ? slot : 2'd0;
    end

endmodule

FILE: rtl/u8u16_outq.sv
// Result queue: takes up to three items a cycle, delivers one item a cycle while the receiver is ready.
module u8u16_outq
    import u8u16_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_room,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    t_item              r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count,  n_count;
    logic               pop;

    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] ptr,
                                                 input logic [1:0] step);
        logic [PTR_W+1:0] sum;
        sum = (PTR_W+2)'(ptr) + (PTR_W+2)'(step);
        if (sum >= (PTR_W+2)'(Q_DEPTH)) begin
            sum = sum - (PTR_W+2)'(Q_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    // A new byte may be processed when three slots are free after this pop.
    assign o_room  = (r_count - QCNT_W'(pop)) <= QCNT_W'(Q_DEPTH - MAX_PUSH);

    // Pointer and occupancy bookkeeping.
    always_comb begin
        n_wr_ptr = ptr_add(r_wr_ptr, i_push.num);
        n_rd_ptr = pop ? ptr_add(r_rd_ptr, 2'd1) : r_rd_ptr;
        n_count  = r_count - QCNT_W'(pop) + QCNT_W'(i_push.num);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Item storage; the pushed items land in consecutive slots.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_PUSH; k++) begin
            if (2'(k) < i_push.num) begin
                r_mem[ptr_add(r_wr_ptr, 2'(k))] <= i_push.item[k];
            end
        end
    end

endmodule

FILE: rtl/utf8_to_utf16_transcoder.sv
// Top level of the UTF-8 to UTF-16 transcoder.
//
// Usage: source bytes of one string enter on the input channel (i_in_valid,
// o_in_ready, i_byte_value, i_last_byte), with i_last_byte set on the final
// byte. Result items leave on the output channel (o_out_valid, i_out_ready):
// a unit item per UTF-16 code unit, and one closing status item per string
// that carries the status code and the unit count. The destination capacity
// is written through i_cfg_we / i_cfg_data while the block is idle.
// Path: an accepted byte is held in the input register, decoded from it
// once the queue has room, and written to the result queue, from which its
// first result is visible on the output channel.
// Throughput: one byte per cycle while each byte yields at most one item and
// the receiver is ready. The output port delivers one item per cycle, so the
// items of a byte that gives a surrogate pair, or a pair plus the closing
// item, leave one after another; that single output port sets this figure.
// Reset clears the string state, empties the queue and sets the capacity to
// 256 units; no clearing pass follows. When the receiver stalls, the queue
// fills, decoding pauses and o_in_ready drops once the input register holds
// a byte.
module utf8_to_utf16_transcoder
    import u8u16_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [BYTE_W-1:0]  i_byte_value,
    input  logic               i_last_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [UNIT_W-1:0]  o_code_unit,
    output logic               o_is_unit,
    output logic [2:0]         o_status,
    output logic [COUNT_W-1:0] o_unit_count,
    output logic               o_end_of_run
);

    logic [COUNT_W-1:0] r_limit;
    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    logic               r_in_last;
    logic               room;
    logic               take;
    t_push              push;
    t_item              item;

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    // Input register; it refills in the cycle its byte is decoded.
    assign take       = r_in_valid && room;
    assign o_in_ready = !r_in_valid || room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_byte_value;
            r_in_last <= i_last_byte;
        end
    end

    u8u16_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_limit (r_limit),
        .o_push  (push)
    );

    u8u16_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (item)
    );

    // Result fields.
    assign o_code_unit  = item.code_unit;
    assign o_is_unit    = item.is_unit;
    assign o_status     = 3'(item.status);
    assign o_unit_count = item.unit_count;
    assign o_end_of_run = item.end_of_run;

endmodule

FILE: rtl/u8u16_chk.sv
// Port-level checker for the transcoder, bound to the top level.
module u8u16_chk
    import u8u16_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [UNIT_W-1:0]  o_code_unit,
    input logic               o_is_unit,
    input logic [2:0]         o_status,
    input logic [COUNT_W-1:0] o_unit_count,
    input logic               o_end_of_run
);

    logic [COUNT_W-1:0] r_seen, n_seen;

    // Units delivered so far in the current string.
    always_comb begin
        n_seen = r_seen;
        if (o_out_valid && i_out_ready) begin
            n_seen = o_is_unit ? r_seen + COUNT_W'(1) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else begin
            r_seen <= n_seen;
        end
    end

    // Unit items carry ok status and never close the string.
    a_unit_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_unit |-> o_status == 3'(ST_OK) && !o_end_of_run)
        else $error("unit item with status or end flag");

    // Each unit item counts one more than the previous one of its string.
    a_unit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_unit |-> o_unit_count == r_seen + COUNT_W'(1))
        else $error("unit count does not advance by one");

    // The closing item reports exactly the units delivered.
    a_close_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_unit |-> o_end_of_run && o_unit_count == r_seen
            && o_code_unit == '0)
        else $error("closing item does not match the delivered units");

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_code_unit)
            && $stable(o_is_unit) && $stable(o_unit_count))
        else $error("stalled result item changed");

endmodule

bind utf8_to_utf16_transcoder u8u16_chk u_chk (.*);
